// ===== sv/positional_insert_delete_list_top_defines.svh =====
// Assertion macros shared by the list block.
`ifndef POSITIONAL_INSERT_DELETE_LIST_TOP_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PIDL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define PIDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pidl_pkg.sv =====
// Types and codes shared by the list controller, datapath and top level.
package pidl_pkg;

    // Command codes; code 7 is unused and answers ok with no change
    typedef enum logic [2:0] {
        CMD_PUSH_TAIL = 3'd0,
        CMD_PUSH_HEAD = 3'd1,
        CMD_POP_TAIL  = 3'd2,
        CMD_POP_HEAD  = 3'd3,
        CMD_INSERT    = 3'd4,
        CMD_ERASE     = 3'd5,
        CMD_READ      = 3'd6
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ===== sv/pidl_ctrl.sv =====
// Controller state machine: sequences capture and execute of one transaction.
module pidl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output pidl_pkg::ctrl_cmd_t   ctrl
);

    pidl_pkg::state_t state_reg;
    pidl_pkg::state_t state_next;
    logic             done_reg;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidl_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctrl.execute;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pidl_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = pidl_pkg::ST_EXEC;
            end
            pidl_pkg::ST_EXEC:
            begin
                state_next = pidl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pidl_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive commands and status
    always_comb
    begin
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        busy         = 1'b0;
        case (state_reg)
            pidl_pkg::ST_IDLE:
            begin
                ctrl.capture = start;
            end
            pidl_pkg::ST_EXEC:
            begin
                ctrl.execute = 1'b1;
                busy         = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== sv/pidl_datapath.sv =====
// Datapath: command registers, row of entry cells with parallel shift, length and result.
module pidl_datapath #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pidl_pkg::ctrl_cmd_t        ctrl,
    input  logic [2:0]                 cmd,
    input  logic [4:0]                 position,
    input  logic signed [31:0]         value,
    output logic [1:0]                 status,
    output logic [CNT_W-1:0]           count,
    output logic signed [31:0]         read_value
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    pidl_pkg::cmd_t     cmd_reg;
    logic [4:0]         pos_reg;
    logic [31:0]        val_reg;
    logic [31:0]        cell_reg  [CAPACITY];
    logic [31:0]        cell_next [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    pidl_pkg::status_t  status_reg;
    pidl_pkg::status_t  status_next;
    logic [31:0]        read_reg;
    logic [31:0]        read_next;

    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   put_idx;
    logic [CMP_W-1:0]   take_idx;
    logic               do_put;
    logic               do_take;
    logic               full;
    logic               empty;
    logic               pos_in_list;
    logic               pos_in_gap;
    logic [4:0]         pos_m1;
    logic [IDX_W-1:0]   rd_idx;

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= pidl_pkg::cmd_t'(cmd);
            pos_reg <= position;
            val_reg <= value;
        end
    end

    assign pos_x       = CMP_W'(pos_reg);
    assign cnt_x       = CMP_W'(count_reg);
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign empty       = (count_reg == '0);
    assign pos_in_list = (pos_reg != 5'd0) && (pos_x <= cnt_x);
    assign pos_in_gap  = (pos_reg != 5'd0) && (pos_x <= cnt_x + CMP_W'(1));
    assign pos_m1      = pos_reg - 5'd1;
    assign rd_idx      = IDX_W'(pos_m1);

    // Decode the command
    always_comb
    begin
        status_next = pidl_pkg::STAT_OK;
        read_next   = '0;
        do_put      = 1'b0;
        do_take     = 1'b0;
        put_idx     = '0;
        take_idx    = '0;
        case (cmd_reg)
            pidl_pkg::CMD_PUSH_TAIL:
            begin
                if (full)
                    status_next = pidl_pkg::STAT_FULL;
                else
                begin
                    do_put  = 1'b1;
                    put_idx = cnt_x;
                end
            end
            pidl_pkg::CMD_PUSH_HEAD:
            begin
                if (full)
                    status_next = pidl_pkg::STAT_FULL;
                else
                    do_put = 1'b1;
            end
            pidl_pkg::CMD_POP_TAIL:
            begin
                if (empty)
                    status_next = pidl_pkg::STAT_EMPTY;
                else
                begin
                    do_take  = 1'b1;
                    take_idx = cnt_x - CMP_W'(1);
                end
            end
            pidl_pkg::CMD_POP_HEAD:
            begin
                if (empty)
                    status_next = pidl_pkg::STAT_EMPTY;
                else
                    do_take = 1'b1;
            end
            pidl_pkg::CMD_INSERT:
            begin
                // position check wins over the full check
                if (!pos_in_gap)
                    status_next = pidl_pkg::STAT_BADPOS;
                else if (full)
                    status_next = pidl_pkg::STAT_FULL;
                else
                begin
                    do_put  = 1'b1;
                    put_idx = CMP_W'(pos_m1);
                end
            end
            pidl_pkg::CMD_ERASE:
            begin
                if (!pos_in_list)
                    status_next = pidl_pkg::STAT_BADPOS;
                else
                begin
                    do_take  = 1'b1;
                    take_idx = CMP_W'(pos_m1);
                end
            end
            pidl_pkg::CMD_READ:
            begin
                if (!pos_in_list)
                    status_next = pidl_pkg::STAT_BADPOS;
                else
                    read_next = cell_reg[rd_idx];
            end
            default:
            begin
                status_next = pidl_pkg::STAT_OK;
            end
        endcase
    end

    // Shift each cell toward the tail on a put, toward the head on a take
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_put)
            begin
                if (CMP_W'(i) == put_idx)
                    cell_next[i] = val_reg;
                else if ((i > 0) && (CMP_W'(i) > put_idx))
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_take)
            begin
                if ((i < CAPACITY - 1) && (CMP_W'(i) >= take_idx))
                    cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    // Update the length
    always_comb
    begin
        count_next = count_reg;
        if (do_put)
            count_next = count_reg + CNT_W'(1);
        else if (do_take)
            count_next = count_reg - CNT_W'(1);
    end

    // Hold the cells and the result
    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            for (int i = 0; i < CAPACITY; i++)
                cell_reg[i] <= cell_next[i];
            status_reg <= status_next;
            read_reg   <= read_next;
        end
    end

    // Hold the length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.execute)
            count_reg <= count_next;
    end

    assign status     = status_reg;
    assign count      = count_reg;
    assign read_value = read_reg;

endmodule

// ===== sv/positional_insert_delete_list_top.sv =====
// Top level of the positional insert and delete list block.
//
//  Channel   Handshake                  Fields
//  command   start in, busy out         cmd, position, value
//  result    done strobe out            status, count, read_value
//
// The accept edge captures the command and enters the execute state; the edge
// that leaves it shifts the row of entry cells and loads the result.
// done is high for one cycle after that edge; busy is high during the shift.
// A new command may be accepted in the cycle that done is high.
// Reset clears the length and the controller; entry cells are not cleared.
// The receiver cannot stall: each result is shown exactly once.
`include "positional_insert_delete_list_top_defines.svh"

module positional_insert_delete_list_top #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          cmd,
    input  logic [4:0]          position,
    input  logic signed [31:0]  value,
    output logic                done,
    output logic [1:0]          status,
    output logic [CNT_W-1:0]    count,
    output logic signed [31:0]  read_value
);

    pidl_pkg::ctrl_cmd_t ctrl;

    // Sequence the transaction
    pidl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Hold the list and compute the result
    pidl_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cmd        (cmd),
        .position   (position),
        .value      (value),
        .status     (status),
        .count      (count),
        .read_value (read_value)
    );

    // Check sequencing and result consistency
    `PIDL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept not followed by busy")
    `PIDL_ASSERT_NEXT(a_busy_done, busy, done && !busy, "execute not followed by result")
    `PIDL_ASSERT_SAME(a_count_cap, done, count <= CNT_W'(CAPACITY), "count above capacity")
    `PIDL_ASSERT_SAME(a_fail_zero, done && (status != pidl_pkg::STAT_OK), read_value == 32'sd0,
                      "failed command returned data")

endmodule
